[hw/rtl/double_ended_queue_defines.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Clocked assertion, muted while reset is held
`define DQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("deque port check failed");

// Clocked assertion that is also checked during reset
`define DQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("deque port check failed");

`endif

[hw/rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Types, codes and beat layout for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned DQ_DEPTH_DEFAULT = 64;

    localparam int unsigned DQ_CMD_W    = 3;
    localparam int unsigned DQ_VALUE_W  = 32;
    localparam int unsigned DQ_STATUS_W = 2;
    localparam int unsigned DQ_COUNT_W  = 7;

    // input beat: command, push_value
    localparam int unsigned DQ_IN_CMD_LSB   = 0;
    localparam int unsigned DQ_IN_VALUE_LSB = DQ_IN_CMD_LSB + DQ_CMD_W;
    localparam int unsigned DQ_IN_USED_W    = DQ_IN_VALUE_LSB + DQ_VALUE_W;
    localparam int unsigned DQ_IN_TDATA_W   = ((DQ_IN_USED_W + 7) / 8) * 8;

    // output beat: popped_value, status, entry_count, is_empty
    localparam int unsigned DQ_OUT_VALUE_LSB  = 0;
    localparam int unsigned DQ_OUT_STATUS_LSB = DQ_OUT_VALUE_LSB + DQ_VALUE_W;
    localparam int unsigned DQ_OUT_COUNT_LSB  = DQ_OUT_STATUS_LSB + DQ_STATUS_W;
    localparam int unsigned DQ_OUT_EMPTY_LSB  = DQ_OUT_COUNT_LSB + DQ_COUNT_W;
    localparam int unsigned DQ_OUT_USED_W     = DQ_OUT_EMPTY_LSB + 1;
    localparam int unsigned DQ_OUT_TDATA_W    = ((DQ_OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [DQ_CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    typedef enum logic [DQ_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

[hw/rtl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [$clog2(DEPTH)-1:0]             wr_addr,
    input  logic [dq_pkg::DQ_VALUE_W-1:0]        wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic [dq_pkg::DQ_VALUE_W-1:0]        rd_data
);
    import dq_pkg::*;

    logic [DQ_VALUE_W-1:0] mem [DEPTH];
    logic [DQ_VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read, so a stalled result stays put
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// A result beat is offered in the cycle after its command beat is accepted.
// Throughput: one command per cycle unless a result beat stalls; front index and
// count update at accept; the RAM takes at most one write or read per command.
// Reset: front index, count and output valid clear; RAM contents are kept.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] command, [34:3] push_value, zero pad above
    input  logic [dq_pkg::DQ_IN_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] popped_value, [33:32] status, [40:34] entry_count, [41] is_empty
    output logic [dq_pkg::DQ_OUT_TDATA_W-1:0]    m_tdata
);
    import dq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg;
    status_t       status_reg, status_next;
    logic [DQ_COUNT_W-1:0] entry_count_reg;
    logic          empty_reg;
    logic          pop_ok_reg, pop_ok_next;

    logic          accept;
    cmd_t          cmd;
    logic [DQ_VALUE_W-1:0] push_value;
    logic          full, empty;
    logic [SW-1:0] back_sum, last_sum, back_wrap, last_wrap;
    logic [AW-1:0] back_slot, last_slot, front_dec, front_inc;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DQ_VALUE_W-1:0] rd_data;
    logic [CW+DQ_COUNT_W-1:0] count_ext;

    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign cmd        = cmd_t'(s_tdata[DQ_IN_CMD_LSB +: DQ_CMD_W]);
    assign push_value = s_tdata[DQ_IN_VALUE_LSB +: DQ_VALUE_W];

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    // ring arithmetic: sums stay below twice the depth, one subtract wraps
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign last_sum  = back_sum - SW'(1);
    assign back_wrap = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
    assign last_wrap = (last_sum >= DEPTH_S) ? last_sum - DEPTH_S : last_sum;
    assign back_slot = back_wrap[AW-1:0];
    assign last_slot = last_wrap[AW-1:0];
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = back_slot;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                    wr_en      = accept;
                    wr_addr    = front_dec;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    wr_en      = accept;
                    wr_addr    = back_slot;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    front_next  = front_inc;
                    count_next  = count_reg - CW'(1);
                    pop_ok_next = 1'b1;
                    rd_en       = accept;
                    rd_addr     = front_reg;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next  = count_reg - CW'(1);
                    pop_ok_next = 1'b1;
                    rd_en       = accept;
                    rd_addr     = last_slot;
                end
            end
            CMD_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // count is reported modulo the field width
    assign count_ext = {{DQ_COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                front_reg   <= front_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg      <= status_next;
            entry_count_reg <= count_ext[DQ_COUNT_W-1:0];
            empty_reg       <= (count_next == '0);
            pop_ok_reg      <= pop_ok_next;
        end
    end

    // a push is visible to a pop in any later command, no bypass needed
    dq_ram #(
        .DEPTH (DEPTH)
    ) u_dq_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[DQ_OUT_VALUE_LSB +: DQ_VALUE_W]   = pop_ok_reg ? rd_data : '0;
        m_tdata[DQ_OUT_STATUS_LSB +: DQ_STATUS_W] = status_reg;
        m_tdata[DQ_OUT_COUNT_LSB +: DQ_COUNT_W]   = entry_count_reg;
        m_tdata[DQ_OUT_EMPTY_LSB]                 = empty_reg;
    end

    assign m_tvalid = m_valid_reg;

endmodule

[hw/rtl/dq_checker.sv]
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_checker #(
    parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH_DEFAULT
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [dq_pkg::DQ_IN_TDATA_W-1:0]  s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dq_pkg::DQ_OUT_TDATA_W-1:0] m_tdata
);
    import dq_pkg::*;

    logic                   s_beat;
    logic [DQ_VALUE_W-1:0]  out_value;
    logic [DQ_STATUS_W-1:0] out_status;
    logic [DQ_COUNT_W-1:0]  out_count;
    logic                   out_empty;

    assign s_beat      = s_tvalid && s_tready;
    assign out_value   = m_tdata[DQ_OUT_VALUE_LSB +: DQ_VALUE_W];
    assign out_status  = m_tdata[DQ_OUT_STATUS_LSB +: DQ_STATUS_W];
    assign out_count   = m_tdata[DQ_OUT_COUNT_LSB +: DQ_COUNT_W];
    assign out_empty   = m_tdata[DQ_OUT_EMPTY_LSB];

    // stalled result beat holds
    `DQ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // every command beat yields a result beat in the next cycle
    `DQ_ASSERT(a_result_follows, aclk, aresetn, s_beat |=> m_tvalid)

    // no waiting result means the input side is open
    `DQ_ASSERT(a_ready_when_idle, aclk, aresetn, !m_tvalid |-> s_tready)

    // empty flag agrees with the count (count wraps only for depths of 128 and up)
    `DQ_ASSERT(a_empty_count, aclk, aresetn, m_tvalid |-> (DEPTH >= 128) || (out_empty == (out_count == '0)))

    // a failed pop leaves an empty queue and no data
    `DQ_ASSERT(a_pop_empty, aclk, aresetn, m_tvalid && (out_status == ST_EMPTY) |-> out_empty && (out_value == '0))

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
